### src/esc_pkg.sv
// Shared types, constants and lookup tables for the epoch seconds to calendar converter.
package esc_pkg;

  localparam int BASE_YEAR    = 1970;
  localparam int YEAR_COUNT   = 137;
  localparam int YEAR_STEPS   = 8;
  localparam int YEAR_SLOTS   = 1 << YEAR_STEPS;
  localparam int MONTH_STAGES = 3;
  localparam int TOD_STAGES   = 4;
  localparam int DATE_STAGES  = YEAR_STEPS + MONTH_STAGES;
  localparam int TOD_PAD      = DATE_STAGES - TOD_STAGES;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0] BASE_WEEKDAY  = 16'd4;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam logic [12:0] HOUR_RECIP  = 13'd4661;
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;

  typedef logic [15:0] day_t;
  typedef logic [16:0] sod_t;
  typedef logic [YEAR_STEPS-1:0] yidx_t;
  typedef logic [YEAR_SLOTS-1:0][16:0] ystart_tab_t;
  typedef logic [YEAR_SLOTS-1:0] leap_tab_t;

  typedef struct packed {
    logic valid;
    day_t days;
    sod_t sod;
  } split_t;

  typedef struct packed {
    logic  valid;
    yidx_t yidx;
    day_t  days;
  } ysrch_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [8:0]  doy;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  localparam logic [11:0][8:0] MONTH_START = {
    9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
    9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
  };

  function automatic logic gregorian_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic ystart_tab_t build_year_start();
    ystart_tab_t tab;
    int acc;
    acc = 0;
    for (int i = 0; i < YEAR_SLOTS; i++) begin
      if (i < YEAR_COUNT) begin
        tab[i] = 17'(acc);
      end else begin
        tab[i] = '1;
      end
      acc = acc + (gregorian_leap(BASE_YEAR + i) ? 366 : 365);
    end
    return tab;
  endfunction

  function automatic leap_tab_t build_leap_tab();
    leap_tab_t tab;
    for (int i = 0; i < YEAR_SLOTS; i++) begin
      tab[i] = gregorian_leap(BASE_YEAR + i);
    end
    return tab;
  endfunction

  localparam ystart_tab_t YEAR_START = build_year_start();
  localparam leap_tab_t   LEAP_TAB   = build_leap_tab();

endpackage

### src/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to Gregorian UTC calendar converter.
// A transaction is taken at every clock edge where start is high; busy never rises, so one
// transaction may follow another in every cycle. Each result appears on the out_ ports with
// out_valid for exactly one cycle, and results leave in the order taken. The result passes
// through a fixed pipeline of 14 register stages: three stages for the input register and
// the day split, eight stages of binary search over the table of year start days, and three
// stages for the month split. The receiver cannot stall the block.
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [8:0]  out_day_of_year,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  split_t split;
  ysrch_t ysrch;
  date_t  date;
  tod_t   tod;
  logic   accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  esc_day_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_t     (in_epoch_seconds),
    .o        (split)
  );

  esc_year_search u_year (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (split.valid),
    .in_days  (split.days),
    .o        (ysrch)
  );

  esc_month_split u_month (
    .clk   (clk),
    .rst_n (rst_n),
    .i     (ysrch),
    .o     (date)
  );

  esc_time_of_day u_tod (
    .clk     (clk),
    .in_days (split.days),
    .in_sod  (split.sod),
    .o       (tod)
  );

  assign out_valid        = date.valid;
  assign out_year         = date.year;
  assign out_month        = date.month;
  assign out_day_of_month = date.dom;
  assign out_day_of_year  = date.doy;
  assign out_hour         = tod.hour;
  assign out_minute       = tod.minute;
  assign out_second       = tod.second;
  assign out_weekday      = tod.weekday;

endmodule

### src/esc_day_split.sv
// Input register and split of the seconds count into whole days and second of day.
module esc_day_split
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_t,
  output split_t      o
);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] t1_r, t2_r;
  day_t        days2_r, days3_r;
  sod_t        sod3_r;

  logic [50:0] prod;
  logic [31:0] dsec;
  day_t        days_nxt;
  sod_t        sod_nxt;

  assign prod     = 51'(t1_r[31:7]) * 51'(DAY_RECIP);
  assign days_nxt = prod[50:35];
  assign dsec     = 32'(days2_r) * SECS_PER_DAY;
  assign sod_nxt  = 17'(t2_r - dsec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= in_t;
    t2_r    <= t1_r;
    days2_r <= days_nxt;
    days3_r <= days2_r;
    sod3_r  <= sod_nxt;
  end

  assign o.valid = v3_r;
  assign o.days  = days3_r;
  assign o.sod   = sod3_r;

endmodule

### src/esc_year_search.sv
// Pipelined binary search of the day count over the table of year start days.
module esc_year_search
  import esc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  day_t   in_days,
  output ysrch_t o
);

  logic  vld_r  [YEAR_STEPS];
  yidx_t idx_r  [YEAR_STEPS];
  day_t  days_r [YEAR_STEPS];

  for (genvar k = 0; k < YEAR_STEPS; k++) begin : g_step
    logic  vld_in;
    yidx_t idx_in;
    day_t  days_in;
    yidx_t cand;
    yidx_t idx_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign idx_in  = '0;
      assign days_in = in_days;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign idx_in  = idx_r[k-1];
      assign days_in = days_r[k-1];
    end

    assign cand    = idx_in | yidx_t'(1 << (YEAR_STEPS - 1 - k));
    assign idx_nxt = (17'(days_in) >= YEAR_START[cand]) ? cand : idx_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      idx_r[k]  <= idx_nxt;
      days_r[k] <= days_in;
    end
  end

  assign o.valid = vld_r[YEAR_STEPS-1];
  assign o.yidx  = idx_r[YEAR_STEPS-1];
  assign o.days  = days_r[YEAR_STEPS-1];

endmodule

### src/esc_month_split.sv
// Day of year, month and day of month from the found year and the day count.
module esc_month_split
  import esc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ysrch_t i,
  output date_t  o
);

  logic        v1_r, v2_r, v3_r;
  logic [8:0]  rem1_r, rem2_r;
  logic        leap1_r, leap2_r;
  logic [11:0] year1_r, year2_r, year3_r;
  logic [3:0]  mi2_r;
  logic [3:0]  month3_r;
  logic [4:0]  dom3_r;
  logic [8:0]  doy3_r;

  logic [16:0] ystart;
  logic [8:0]  rem_nxt;
  logic [3:0]  mi_nxt;
  logic [8:0]  mstart;
  logic [4:0]  dom_nxt;

  assign ystart  = YEAR_START[i.yidx];
  assign rem_nxt = 9'(17'(i.days) - ystart);

  always_comb begin
    mi_nxt = '0;
    for (int m = 1; m < 12; m++) begin
      if (rem1_r >= MONTH_START[4'(m)] + 9'(leap1_r && (m >= 2))) begin
        mi_nxt = 4'(m);
      end
    end
  end

  assign mstart  = MONTH_START[mi2_r] + 9'(leap2_r && (mi2_r >= 4'd2));
  assign dom_nxt = 5'(rem2_r - mstart + 9'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= i.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    rem1_r   <= rem_nxt;
    leap1_r  <= LEAP_TAB[i.yidx];
    year1_r  <= 12'(BASE_YEAR) + 12'(i.yidx);
    rem2_r   <= rem1_r;
    leap2_r  <= leap1_r;
    year2_r  <= year1_r;
    mi2_r    <= mi_nxt;
    year3_r  <= year2_r;
    month3_r <= mi2_r + 4'd1;
    dom3_r   <= dom_nxt;
    doy3_r   <= rem2_r + 9'd1;
  end

  assign o.valid = v3_r;
  assign o.year  = year3_r;
  assign o.month = month3_r;
  assign o.dom   = dom3_r;
  assign o.doy   = doy3_r;

endmodule

### src/esc_time_of_day.sv
// Hour, minute, second and weekday, delayed to line up with the date path.
module esc_time_of_day
  import esc_pkg::*;
(
  input  logic clk,
  input  day_t in_days,
  input  sod_t in_sod,
  output tod_t o
);

  sod_t        sod1_r;
  logic [4:0]  hour1_r, hour2_r, hour3_r, hour4_r;
  logic [15:0] w1_r;
  logic [12:0] q1_r;
  logic [11:0] rsec2_r, rsec3_r;
  logic [2:0]  wd2_r, wd3_r, wd4_r;
  logic [5:0]  min3_r, min4_r;
  logic [5:0]  sec4_r;
  tod_t        pad_r [TOD_PAD];

  logic [15:0] w_nxt;
  logic [25:0] hprod;
  logic [32:0] wprod;
  logic [20:0] mprod;
  logic [16:0] hsec;
  logic [15:0] wsub;
  logic [11:0] msec;
  tod_t        tod4;

  assign w_nxt = in_days + BASE_WEEKDAY;
  assign hprod = 26'(in_sod[16:4]) * 26'(HOUR_RECIP);
  assign wprod = 33'(w_nxt) * 33'(WEEK_RECIP);
  assign hsec  = 17'(hour1_r) * SECS_PER_HOUR;
  assign wsub  = 16'(q1_r) * DAYS_PER_WEEK;
  assign mprod = 21'(rsec2_r[11:2]) * 21'(MIN_RECIP);
  assign msec  = 12'(min3_r) * SECS_PER_MIN;

  always_ff @(posedge clk) begin
    sod1_r  <= in_sod;
    hour1_r <= hprod[24:20];
    w1_r    <= w_nxt;
    q1_r    <= wprod[31:19];
    rsec2_r <= 12'(sod1_r - hsec);
    hour2_r <= hour1_r;
    wd2_r   <= 3'(w1_r - wsub);
    rsec3_r <= rsec2_r;
    hour3_r <= hour2_r;
    wd3_r   <= wd2_r;
    min3_r  <= mprod[19:14];
    hour4_r <= hour3_r;
    wd4_r   <= wd3_r;
    min4_r  <= min3_r;
    sec4_r  <= 6'(rsec3_r - msec);
  end

  assign tod4.hour    = hour4_r;
  assign tod4.minute  = min4_r;
  assign tod4.second  = sec4_r;
  assign tod4.weekday = wd4_r;

  always_ff @(posedge clk) begin
    pad_r[0] <= tod4;
    for (int k = 1; k < TOD_PAD; k++) begin
      pad_r[k] <= pad_r[k-1];
    end
  end

  assign o = pad_r[TOD_PAD-1];

endmodule
